### hdl/bccu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bccu_pkg: shared types for the box/circle contact unit
// Pair-kind codes and the stage control group that the pipeline blocks share.
// ----------------------------------------------------------------------------
package bccu_pkg;

  typedef enum logic [1:0] {
    CMD_BOX_BOX       = 2'd0,
    CMD_BOX_CIRCLE    = 2'd1,
    CMD_CIRCLE_CIRCLE = 2'd2,
    CMD_CIRCLE_BOX    = 2'd3
  } cmd_t;

  // en advances every stage at once; valid marks an item entering the block
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

### hdl/bccu_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bccu_sqrt: pipelined integer square root
// One result bit per stage, floor of the exact root; a sideband word rides along.
// ----------------------------------------------------------------------------
module bccu_sqrt #(
  parameter int RW = 66,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  bccu_pkg::pipe_ctl_t ctl,
  input  logic [RW-1:0]       radicand,
  input  logic [PW-1:0]       side_in,
  output logic                out_valid,
  output logic [RW/2-1:0]     root,
  output logic [PW-1:0]       side_out
);
  import bccu_pkg::*;

  localparam int QW   = RW / 2;
  localparam int REMW = QW + 2;

  logic            vld [1:QW];
  logic [RW-1:0]   rad [1:QW];
  logic [REMW-1:0] rem [1:QW];
  logic [QW-1:0]   rt  [1:QW];
  logic [PW-1:0]   sd  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic            iv;
    logic [RW-1:0]   irad;
    logic [REMW-1:0] irem;
    logic [QW-1:0]   irt;
    logic [PW-1:0]   isd;
    logic [REMW-1:0] cand;
    logic [REMW-1:0] sub;
    logic [REMW:0]   diff;

    if (k == 0) begin : g_first
      assign iv   = ctl.valid;
      assign irad = radicand;
      assign irem = '0;
      assign irt  = '0;
      assign isd  = side_in;
    end else begin : g_next
      assign iv   = vld[k];
      assign irad = rad[k];
      assign irem = rem[k];
      assign irt  = rt[k];
      assign isd  = sd[k];
    end

    // bring down two radicand bits, try 4*root+1
    assign cand = {irem[REMW-3:0], irad[RW-1 -: 2]};
    assign sub  = {irt, 2'b01};
    assign diff = {1'b0, cand} - {1'b0, sub};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vld[k+1] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rad[k+1] <= irad << 2;
        rem[k+1] <= diff[REMW] ? cand : diff[REMW-1:0];
        rt[k+1]  <= {irt[QW-2:0], ~diff[REMW]};
        sd[k+1]  <= isd;
      end
    end
  end

  assign out_valid = vld[QW];
  assign root      = rt[QW];
  assign side_out  = sd[QW];

endmodule
`default_nettype wire

### hdl/bccu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bccu_div: two-lane pipelined fraction divider
// Computes (num << (QB-1)) / den per lane, one quotient bit per stage,
// for numerators not above the shared denominator.
// ----------------------------------------------------------------------------
module bccu_div #(
  parameter int DW = 33,
  parameter int QB = 17,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  bccu_pkg::pipe_ctl_t ctl,
  input  logic [DW-1:0]       num_x,
  input  logic [DW-1:0]       num_y,
  input  logic [DW-1:0]       den,
  input  logic [PW-1:0]       side_in,
  output logic                out_valid,
  output logic [QB-1:0]       quo_x,
  output logic [QB-1:0]       quo_y,
  output logic [PW-1:0]       side_out
);
  import bccu_pkg::*;

  localparam int RWD = DW + 1;

  logic           vld [1:QB];
  logic [RWD-1:0] rx  [1:QB];
  logic [RWD-1:0] ry  [1:QB];
  logic [QB-1:0]  qx  [1:QB];
  logic [QB-1:0]  qy  [1:QB];
  logic [DW-1:0]  dn  [1:QB];
  logic [PW-1:0]  sd  [1:QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic           iv;
    logic [RWD-1:0] irx, iry, cx, cy, dd;
    logic [QB-1:0]  iqx, iqy;
    logic [DW-1:0]  idn;
    logic [PW-1:0]  isd;
    logic           gx, gy;

    if (k == 0) begin : g_first
      assign iv  = ctl.valid;
      assign irx = RWD'(num_x);
      assign iry = RWD'(num_y);
      assign iqx = '0;
      assign iqy = '0;
      assign idn = den;
      assign isd = side_in;
      // top quotient bit: compare without a shift
      assign cx  = irx;
      assign cy  = iry;
    end else begin : g_next
      assign iv  = vld[k];
      assign irx = rx[k];
      assign iry = ry[k];
      assign iqx = qx[k];
      assign iqy = qy[k];
      assign idn = dn[k];
      assign isd = sd[k];
      assign cx  = {irx[DW-1:0], 1'b0};
      assign cy  = {iry[DW-1:0], 1'b0};
    end

    assign dd = RWD'(idn);
    assign gx = (cx >= dd);
    assign gy = (cy >= dd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vld[k+1] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rx[k+1] <= gx ? (cx - dd) : cx;
        ry[k+1] <= gy ? (cy - dd) : cy;
        qx[k+1] <= {iqx[QB-2:0], gx};
        qy[k+1] <= {iqy[QB-2:0], gy};
        dn[k+1] <= idn;
        sd[k+1] <= isd;
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo_x     = qx[QB];
  assign quo_y     = qy[QB];
  assign side_out  = sd[QB];

endmodule
`default_nettype wire

### hdl/box_circle_contact_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_circle_contact_unit: narrow-phase contact test for box and circle pairs
// Streams shape pairs in, one contact result out per pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input item on s_*: s_tuser carries the pair kind, s_tdata the eight
//   shape words (A then B). Output item on m_*: m_tuser is the hit flag,
//   m_tdata the contact point, normal and depth; all zero when no hit.
//   The pipeline has four front stages (clamp/differences, magnitudes,
//   squares, distance compare), COORD_WIDTH+1 square-root stages,
//   FRAC_BITS+1 divider stages, one scaling stage and the output
//   register.
//   Throughput is one item per cycle unless the receiver stalls; the
//   one-bit-per-stage root and divider pipelines set the depth, not the rate.
//   Reset clears every stage valid bit; the pipe comes out empty and ready.
//   When the receiver holds m_tready low with a result waiting, all stages
//   freeze together and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module box_circle_contact_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  // command
  input  logic [1:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // contact_x, contact_y, normal_x, normal_y, depth
  output logic [((5*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
  // hit
  output logic                                    m_tuser
);
  import bccu_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int ODW = ((5*CW+7)/8)*8;
  localparam int MW  = CW + 1;
  localparam int SQW = 2 * MW;
  localparam int BW  = CW + 3;
  localparam int QB  = FB + 1;
  localparam int WS  = ((CW > FB) ? CW : FB) + 4;
  localparam int PRW = QB + CW;

  localparam logic signed [WS-1:0] CMAXW = $signed({{(WS-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [WS-1:0] CMINW = ~CMAXW;
  localparam logic signed [WS-1:0] ONEW  = $signed(WS'(1) << FB);
  localparam logic [QB-1:0]        ONEQ  = QB'(1) << FB;

  typedef struct packed {
    cmd_t                 cmd;
    logic signed [MW-1:0] ux, uy, rr;
    logic signed [CW-1:0] bsx, bsy, rad;
    logic                 rneg;
    logic signed [MW-1:0] sxa, sxb, sya, syb, wxa, wxb, wya, wyb;
    logic signed [CW-1:0] mxx, mnx, mxy, mny;
    logic signed [CW-1:0] a0, a1, a2, a3;
  } s1_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [MW-1:0]          mux, muy, mrr;
    logic                   uxn, uyn, rneg;
    logic signed [MW-1:0]   rr;
    logic signed [CW-1:0]   bsx, bsy, rad;
    logic signed [CW+1:0]   dx2, dy2, wsx, wsy;
    logic signed [CW-1:0]   pmx, pmy, hax, hay;
    logic signed [CW-1:0]   a0, a1, a2, a3;
  } s2_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [SQW-1:0]       sqx, sqy, sqr;
    logic [MW-1:0]        mux, muy;
    logic                 uxn, uyn, rneg;
    logic signed [MW-1:0] rr;
    logic signed [CW-1:0] bsx, bsy, rad;
    logic signed [BW-1:0] ox2, oy2;
    logic                 sxp, sxn, syp, syn;
    logic signed [CW-1:0] pmx, pmy, hax, hay;
    logic signed [CW-1:0] a0, a1, a2, a3;
  } s3_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic                 hit, zero;
    logic signed [CW-1:0] bpx, bpy;
    logic                 bnxp, bnxn, bnyp, bnyn;
    logic signed [WS-1:0] bdep;
    logic [MW-1:0]        mux, muy;
    logic                 uxn, uyn;
    logic signed [MW-1:0] rr;
    logic signed [CW-1:0] bsx, bsy, rad;
  } sd_t;

  typedef struct packed {
    logic [MW-1:0] len;
    sd_t           sd;
  } dv_t;

  typedef struct packed {
    sd_t                  sd;
    logic signed [WS-1:0] nxc, nyc, dl;
    logic [PRW-1:0]       prx, pry;
    logic                 scnx, scny;
  } b1_t;

  function automatic logic [CW-1:0] sat_c(input logic signed [WS-1:0] v);
    return (v > CMAXW) ? CW'(CMAXW) : ((v < CMINW) ? CW'(CMINW) : CW'(v));
  endfunction

  logic      en;
  pipe_ctl_t sq_ctl, dv_ctl;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: pick box/circle, clamp, differences ----------
  logic signed [CW-1:0] fa [4];
  logic signed [CW-1:0] fb [4];
  s1_t  s1_n, s1;
  logic s1v;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fa[i] = s_tdata[i*CW +: CW];
      fb[i] = s_tdata[(i+4)*CW +: CW];
    end
  end

  always_comb begin
    logic                 is_cb, is_cc;
    logic signed [CW-1:0] kb [4];
    logic signed [CW-1:0] ci [4];
    logic signed [CW-1:0] qx, qy;
    cmd_t                 cmd_in;
    cmd_in = cmd_t'(s_tuser);
    is_cb  = (cmd_in == CMD_CIRCLE_BOX);
    is_cc  = (cmd_in == CMD_CIRCLE_CIRCLE);
    for (int i = 0; i < 4; i++) begin
      kb[i] = is_cb ? fb[i] : fa[i];
      ci[i] = is_cb ? fa[i] : fb[i];
    end
    qx = (ci[0] < kb[0]) ? kb[0] : ((ci[0] > kb[2]) ? kb[2] : ci[0]);
    qy = (ci[1] < kb[1]) ? kb[1] : ((ci[1] > kb[3]) ? kb[3] : ci[1]);
    s1_n.cmd  = cmd_in;
    s1_n.ux   = is_cc ? (MW'(fb[0]) - MW'(fa[0])) : (MW'(ci[0]) - MW'(qx));
    s1_n.uy   = is_cc ? (MW'(fb[1]) - MW'(fa[1])) : (MW'(ci[1]) - MW'(qy));
    s1_n.rr   = is_cc ? (MW'(fa[2]) + MW'(fb[2])) : MW'(ci[2]);
    s1_n.bsx  = is_cc ? fa[0] : qx;
    s1_n.bsy  = is_cc ? fa[1] : qy;
    s1_n.rad  = is_cc ? fa[2] : ci[2];
    s1_n.rneg = ci[2][CW-1];
    s1_n.sxa  = MW'(fa[0]) + MW'(fa[2]);
    s1_n.sxb  = MW'(fb[0]) + MW'(fb[2]);
    s1_n.sya  = MW'(fa[1]) + MW'(fa[3]);
    s1_n.syb  = MW'(fb[1]) + MW'(fb[3]);
    s1_n.wxa  = MW'(fa[2]) - MW'(fa[0]);
    s1_n.wxb  = MW'(fb[2]) - MW'(fb[0]);
    s1_n.wya  = MW'(fa[3]) - MW'(fa[1]);
    s1_n.wyb  = MW'(fb[3]) - MW'(fb[1]);
    s1_n.mxx  = (fa[0] > fb[0]) ? fa[0] : fb[0];
    s1_n.mnx  = (fa[2] < fb[2]) ? fa[2] : fb[2];
    s1_n.mxy  = (fa[1] > fb[1]) ? fa[1] : fb[1];
    s1_n.mny  = (fa[3] < fb[3]) ? fa[3] : fb[3];
    s1_n.a0   = fa[0];
    s1_n.a1   = fa[1];
    s1_n.a2   = fa[2];
    s1_n.a3   = fa[3];
  end

  // ---------------- stage 2: magnitudes, centre offsets, midpoints --------
  s2_t  s2_n, s2;
  logic s2v;

  always_comb begin
    s2_n.cmd  = s1.cmd;
    s2_n.mux  = s1.ux[MW-1] ? MW'(-s1.ux) : MW'(s1.ux);
    s2_n.muy  = s1.uy[MW-1] ? MW'(-s1.uy) : MW'(s1.uy);
    s2_n.mrr  = s1.rr[MW-1] ? MW'(-s1.rr) : MW'(s1.rr);
    s2_n.uxn  = s1.ux[MW-1];
    s2_n.uyn  = s1.uy[MW-1];
    s2_n.rneg = s1.rneg;
    s2_n.rr   = s1.rr;
    s2_n.bsx  = s1.bsx;
    s2_n.bsy  = s1.bsy;
    s2_n.rad  = s1.rad;
    s2_n.dx2  = (CW+2)'(s1.sxb) - (CW+2)'(s1.sxa);
    s2_n.dy2  = (CW+2)'(s1.syb) - (CW+2)'(s1.sya);
    s2_n.wsx  = (CW+2)'(s1.wxa) + (CW+2)'(s1.wxb);
    s2_n.wsy  = (CW+2)'(s1.wya) + (CW+2)'(s1.wyb);
    // halves round toward minus infinity
    s2_n.pmx  = CW'((MW'(s1.mxx) + MW'(s1.mnx)) >>> 1);
    s2_n.pmy  = CW'((MW'(s1.mxy) + MW'(s1.mny)) >>> 1);
    s2_n.hax  = CW'(s1.sxa >>> 1);
    s2_n.hay  = CW'(s1.sya >>> 1);
    s2_n.a0   = s1.a0;
    s2_n.a1   = s1.a1;
    s2_n.a2   = s1.a2;
    s2_n.a3   = s1.a3;
  end

  // ---------------- stage 3: squares, box overlaps ------------------------
  s3_t  s3_n, s3;
  logic s3v;

  always_comb begin
    logic signed [BW-1:0] adx, ady;
    adx       = s2.dx2[CW+1] ? -BW'(s2.dx2) : BW'(s2.dx2);
    ady       = s2.dy2[CW+1] ? -BW'(s2.dy2) : BW'(s2.dy2);
    s3_n.cmd  = s2.cmd;
    s3_n.sqx  = s2.mux * s2.mux;
    s3_n.sqy  = s2.muy * s2.muy;
    s3_n.sqr  = s2.mrr * s2.mrr;
    s3_n.mux  = s2.mux;
    s3_n.muy  = s2.muy;
    s3_n.uxn  = s2.uxn;
    s3_n.uyn  = s2.uyn;
    s3_n.rneg = s2.rneg;
    s3_n.rr   = s2.rr;
    s3_n.bsx  = s2.bsx;
    s3_n.bsy  = s2.bsy;
    s3_n.rad  = s2.rad;
    s3_n.ox2  = BW'(s2.wsx) - adx;
    s3_n.oy2  = BW'(s2.wsy) - ady;
    s3_n.sxp  = !s2.dx2[CW+1] && (s2.dx2 != '0);
    s3_n.sxn  = s2.dx2[CW+1];
    s3_n.syp  = !s2.dy2[CW+1] && (s2.dy2 != '0);
    s3_n.syn  = s2.dy2[CW+1];
    s3_n.pmx  = s2.pmx;
    s3_n.pmy  = s2.pmy;
    s3_n.hax  = s2.hax;
    s3_n.hay  = s2.hay;
    s3_n.a0   = s2.a0;
    s3_n.a1   = s2.a1;
    s3_n.a2   = s2.a2;
    s3_n.a3   = s2.a3;
  end

  // ---------------- stage 4: distance test, box-box answer ----------------
  sd_t            s4_n, s4;
  logic [SQW-1:0] d2_n, d2;
  logic           s4v;

  always_comb begin
    logic le, bbhit;
    d2_n   = s3.sqx + s3.sqy;
    le     = (d2_n <= s3.sqr);
    bbhit  = !s3.ox2[BW-1] && !s3.oy2[BW-1];
    s4_n.cmd  = s3.cmd;
    s4_n.zero = (d2_n == '0);
    unique case (s3.cmd)
      CMD_BOX_BOX:       s4_n.hit = bbhit;
      CMD_CIRCLE_CIRCLE: s4_n.hit = le;
      default:           s4_n.hit = !s3.rneg && le;
    endcase
    if (s3.ox2 >= s3.oy2) begin
      s4_n.bnxp = 1'b0;
      s4_n.bnxn = 1'b0;
      s4_n.bnyp = s3.syp;
      s4_n.bnyn = s3.syn;
      s4_n.bpx  = s3.pmx;
      s4_n.bpy  = s3.syp ? s3.a3 : (s3.syn ? s3.a1 : s3.hay);
      s4_n.bdep = WS'(s3.oy2 >>> 1);
    end else begin
      s4_n.bnxp = s3.sxp;
      s4_n.bnxn = s3.sxn;
      s4_n.bnyp = 1'b0;
      s4_n.bnyn = 1'b0;
      s4_n.bpx  = s3.sxp ? s3.a2 : (s3.sxn ? s3.a0 : s3.hax);
      s4_n.bpy  = s3.pmy;
      s4_n.bdep = WS'(s3.ox2 >>> 1);
    end
    s4_n.mux = s3.mux;
    s4_n.muy = s3.muy;
    s4_n.uxn = s3.uxn;
    s4_n.uyn = s3.uyn;
    s4_n.rr  = s3.rr;
    s4_n.bsx = s3.bsx;
    s4_n.bsy = s3.bsy;
    s4_n.rad = s3.rad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
    end else if (en) begin
      s1v <= s_tvalid;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_n;
      s2 <= s2_n;
      s3 <= s3_n;
      s4 <= s4_n;
      d2 <= d2_n;
    end
  end

  // ---------------- distance, then unit normal ----------------------------
  logic                  sq_valid;
  logic [MW-1:0]         sq_root;
  logic [$bits(sd_t)-1:0] sq_side_v;
  sd_t                   sq_side;
  dv_t                   dv_in;
  logic                  dv_valid;
  logic [QB-1:0]         dv_qx, dv_qy;
  logic [$bits(dv_t)-1:0] dv_side_v;
  dv_t                   dv_side;

  assign sq_ctl = '{en: en, valid: s4v};

  bccu_sqrt #(.RW(SQW), .PW($bits(sd_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sq_ctl),
    .radicand (d2),
    .side_in  (s4),
    .out_valid(sq_valid),
    .root     (sq_root),
    .side_out (sq_side_v)
  );

  assign sq_side    = sd_t'(sq_side_v);
  assign dv_in.len  = sq_root;
  assign dv_in.sd   = sq_side;
  assign dv_ctl     = '{en: en, valid: sq_valid};

  bccu_div #(.DW(MW), .QB(QB), .PW($bits(dv_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dv_ctl),
    .num_x    (sq_side.mux),
    .num_y    (sq_side.muy),
    .den      (sq_root),
    .side_in  (dv_in),
    .out_valid(dv_valid),
    .quo_x    (dv_qx),
    .quo_y    (dv_qy),
    .side_out (dv_side_v)
  );

  assign dv_side = dv_t'(dv_side_v);

  // ---------------- back stage 1: signed normal, radius scaling -----------
  b1_t  b1_n, b1;
  logic b1v;

  always_comb begin
    logic signed [WS-1:0] qxs, qys;
    logic [CW-1:0]        rmag;
    qxs       = WS'(dv_qx);
    qys       = WS'(dv_qy);
    rmag      = dv_side.sd.rad[CW-1] ? CW'(-dv_side.sd.rad) : CW'(dv_side.sd.rad);
    b1_n.sd   = dv_side.sd;
    b1_n.nxc  = dv_side.sd.uxn ? -qxs : qxs;
    b1_n.nyc  = dv_side.sd.uyn ? -qys : qys;
    b1_n.prx  = PRW'(dv_qx) * PRW'(rmag);
    b1_n.pry  = PRW'(dv_qy) * PRW'(rmag);
    b1_n.scnx = dv_side.sd.uxn ^ dv_side.sd.rad[CW-1];
    b1_n.scny = dv_side.sd.uyn ^ dv_side.sd.rad[CW-1];
    b1_n.dl   = WS'(dv_side.sd.rr) - WS'(dv_side.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0;
    end else if (en) begin
      b1v <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= b1_n;
    end
  end

  // ---------------- back stage 2: select by pair kind, saturate -----------
  logic signed [WS-1:0] o_px, o_py, o_nx, o_ny, o_dp;
  logic [ODW-1:0]       o_data;

  always_comb begin
    logic signed [WS-1:0] scx, scy, cpx, cpy;
    scx  = WS'(b1.prx >> FB);
    scy  = WS'(b1.pry >> FB);
    cpx  = WS'(b1.sd.bsx) + (b1.scnx ? -scx : scx);
    cpy  = WS'(b1.sd.bsy) + (b1.scny ? -scy : scy);
    o_px = '0;
    o_py = '0;
    o_nx = '0;
    o_ny = '0;
    o_dp = '0;
    if (b1.sd.hit) begin
      unique case (b1.sd.cmd)
        CMD_BOX_BOX: begin
          o_px = WS'(b1.sd.bpx);
          o_py = WS'(b1.sd.bpy);
          o_nx = b1.sd.bnxp ? ONEW : (b1.sd.bnxn ? -ONEW : '0);
          o_ny = b1.sd.bnyp ? ONEW : (b1.sd.bnyn ? -ONEW : '0);
          o_dp = b1.sd.bdep;
        end
        CMD_BOX_CIRCLE: begin
          o_px = WS'(b1.sd.bsx);
          o_py = WS'(b1.sd.bsy);
          o_nx = b1.sd.zero ? '0 : b1.nxc;
          o_ny = b1.sd.zero ? '0 : b1.nyc;
          o_dp = b1.dl;
        end
        CMD_CIRCLE_BOX: begin
          // same test with shapes swapped; flip the normal
          o_px = WS'(b1.sd.bsx);
          o_py = WS'(b1.sd.bsy);
          o_nx = b1.sd.zero ? '0 : -b1.nxc;
          o_ny = b1.sd.zero ? '0 : -b1.nyc;
          o_dp = b1.dl;
        end
        CMD_CIRCLE_CIRCLE: begin
          if (b1.sd.zero) begin
            // coincident centres: point up, depth is radius A
            o_px = WS'(b1.sd.bsx);
            o_py = WS'(b1.sd.bsy);
            o_ny = ONEW;
            o_dp = WS'(b1.sd.rad);
          end else begin
            o_px = cpx;
            o_py = cpy;
            o_nx = b1.nxc;
            o_ny = b1.nyc;
            o_dp = b1.dl[WS-1] ? -b1.dl : b1.dl;
          end
        end
      endcase
    end
    o_data = ODW'({sat_c(o_dp), sat_c(o_ny), sat_c(o_nx), sat_c(o_py), sat_c(o_px)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= b1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= o_data;
      m_tuser <= b1.sd.hit;
    end
  end

  // ---------------- checks ------------------------------------------------
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("result without hit carries nonzero data");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    dv_valid && !dv_side.sd.zero |-> (dv_qx <= ONEQ) && (dv_qy <= ONEQ))
    else $error("normal component exceeds one");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the box/circle contact unit
// Drives shape pairs of every kind into the slave side, predicts each contact
// result and checks it in order against the master side, under several
// sender/receiver idling patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bccu_pkg::*;

  typedef struct {
    cmd_t cmd;
    int   v[8]; // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1
  } pair_t;

  typedef struct {
    bit     hit;
    longint px, py, nx, ny, depth;
  } contact_t;

  typedef struct {
    logic        hit;
    logic [31:0] f[5]; // contact_x, contact_y, normal_x, normal_y, depth
  } result_t;

  localparam longint ONE = 64'sd65536;

  class contact_scoreboard;
    result_t pending[$];
    int errors;
    int matched;
    int hits;
    int per_cmd[4];

    function bit [127:0] sq(longint v);
      bit [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
    endfunction

    function longint unsigned isqrt(bit [127:0] x);
      longint unsigned r, t;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (128'(t) * 128'(t) <= x) r = t;
      end
      return r;
    endfunction

    function longint unit_comp(longint v, longint unsigned len);
      longint unsigned m, q;
      m = (v < 0) ? longint'(-v) : longint'(v);
      q = (m << 16) / len;
      return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint scale_by(longint n, longint r);
      bit [127:0] p;
      longint unsigned m;
      p = 128'((n < 0) ? -n : n) * 128'((r < 0) ? -r : r);
      m = 64'(p >> 16);
      return ((n < 0) != (r < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function contact_t box_box(longint a[4], longint b[4]);
      contact_t c;
      longint dx2, dy2, ox2, oy2, s;
      c = '{default: 0};
      dx2 = (b[0] + b[2]) - (a[0] + a[2]);
      dy2 = (b[1] + b[3]) - (a[1] + a[3]);
      ox2 = (a[2] - a[0]) + (b[2] - b[0]) - ((dx2 < 0) ? -dx2 : dx2);
      oy2 = (a[3] - a[1]) + (b[3] - b[1]) - ((dy2 < 0) ? -dy2 : dy2);
      if (ox2 < 0 || oy2 < 0) return c;
      c.hit = 1;
      // floor halves: arithmetic shift
      if (ox2 >= oy2) begin
        s = sgn(dy2);
        c.ny = s * ONE;
        c.px = ((a[0] > b[0] ? a[0] : b[0]) + (a[2] < b[2] ? a[2] : b[2])) >>> 1;
        c.py = (s > 0) ? a[3] : ((s < 0) ? a[1] : (a[1] + a[3]) >>> 1);
        c.depth = oy2 >>> 1;
      end else begin
        s = sgn(dx2);
        c.nx = s * ONE;
        c.px = (s > 0) ? a[2] : ((s < 0) ? a[0] : (a[0] + a[2]) >>> 1);
        c.py = ((a[1] > b[1] ? a[1] : b[1]) + (a[3] < b[3] ? a[3] : b[3])) >>> 1;
        c.depth = ox2 >>> 1;
      end
      return c;
    endfunction

    function contact_t box_circle(longint bx[4], longint ci[4]);
      contact_t c;
      longint qx, qy, dx, dy, r;
      bit [127:0] d2;
      longint unsigned len;
      c = '{default: 0};
      qx = clamp(ci[0], bx[0], bx[2]);
      qy = clamp(ci[1], bx[1], bx[3]);
      dx = ci[0] - qx;
      dy = ci[1] - qy;
      r = ci[2];
      d2 = sq(dx) + sq(dy);
      if (r < 0 || d2 > sq(r)) return c;
      len = isqrt(d2);
      c.hit = 1;
      c.px = qx;
      c.py = qy;
      // centre inside the box leaves the normal at zero
      if (len != 0) begin
        c.nx = unit_comp(dx, len);
        c.ny = unit_comp(dy, len);
      end
      c.depth = r - longint'(len);
      return c;
    endfunction

    function contact_t circle_circle(longint a[4], longint b[4]);
      contact_t c;
      longint dx, dy, pen;
      bit [127:0] d2;
      longint unsigned cdist;
      c = '{default: 0};
      dx = b[0] - a[0];
      dy = b[1] - a[1];
      d2 = sq(dx) + sq(dy);
      if (d2 > sq(a[2] + b[2])) return c;
      c.hit = 1;
      if (d2 == 0) begin
        c.px = a[0];
        c.py = a[1];
        c.ny = ONE;
        c.depth = a[2];
        return c;
      end
      cdist = isqrt(d2);
      c.nx = unit_comp(dx, cdist);
      c.ny = unit_comp(dy, cdist);
      c.px = a[0] + scale_by(c.nx, a[2]);
      c.py = a[1] + scale_by(c.ny, a[2]);
      pen = a[2] - (longint'(cdist) - b[2]);
      c.depth = (pen < 0) ? -pen : pen;
      return c;
    endfunction

    function logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note(pair_t p);
      longint a[4], b[4];
      contact_t c;
      result_t r;
      for (int i = 0; i < 4; i++) begin
        a[i] = longint'(p.v[i]);
        b[i] = longint'(p.v[4 + i]);
      end
      case (p.cmd)
        CMD_BOX_BOX:       c = box_box(a, b);
        CMD_BOX_CIRCLE:    c = box_circle(a, b);
        CMD_CIRCLE_CIRCLE: c = circle_circle(a, b);
        default: begin
          c = box_circle(b, a);
          c.nx = -c.nx;
          c.ny = -c.ny;
        end
      endcase
      r.hit = c.hit;
      r.f[0] = sat32(c.px);
      r.f[1] = sat32(c.py);
      r.f[2] = sat32(c.nx);
      r.f[3] = sat32(c.ny);
      r.f[4] = sat32(c.depth);
      hits += c.hit;
      per_cmd[p.cmd]++;
      pending = {pending, r};
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %h got %h (result %0d)", what, want, got, matched);
      errors++;
    endtask

    task check(logic hit, logic [159:0] data);
      string names[5] = '{"contact_x", "contact_y", "normal_x", "normal_y", "depth"};
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 32'h0, {31'h0, hit});
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit) report("hit", {31'h0, want.hit}, {31'h0, hit});
      for (int i = 0; i < 5; i++)
        if (data[32*i +: 32] !== want.f[i]) report(names[i], want.f[i], data[32*i +: 32]);
      matched++;
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [255:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;
  logic         m_tuser;

  box_circle_contact_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  contact_scoreboard contacts = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int quiet_cycles   = 0;
  localparam int QUIET_LIMIT = 5000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = CMD_BOX_BOX;
    m_tready = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // receiver: check results, then pick tready for the next edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) contacts.check(m_tuser, m_tdata);
      if (hold_cycles > 0) begin
        m_tready <= 0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= p.cmd;
    s_tdata  <= {p.v[7], p.v[6], p.v[5], p.v[4], p.v[3], p.v[2], p.v[1], p.v[0]};
    do @(posedge clk); while (!s_tready);
    contacts.note(p);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (contacts.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pair_t mk(cmd_t cmd, int a0, int a1, int a2, int a3,
                               int b0, int b1, int b2, int b3);
    pair_t p;
    p.cmd = cmd;
    p.v = '{a0, a1, a2, a3, b0, b1, b2, b3};
    return p;
  endfunction

  function automatic int span(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // shape A then B; most pairs sit close enough to touch
  function automatic pair_t random_pair();
    pair_t p;
    int scale, cx, cy, w;
    p.cmd = cmd_t'($urandom_range(3));
    if ($urandom_range(99) < 12) begin
      for (int i = 0; i < 8; i++) p.v[i] = $urandom;
      return p;
    end
    case ($urandom_range(3))
      0: scale = 1 << 10;
      1: scale = 1 << 18;
      2: scale = 1 << 22;
      default: scale = 1 << 28;
    endcase
    cx = span(scale);
    cy = span(scale);
    for (int s = 0; s < 2; s++) begin
      w = $urandom_range(scale);
      p.v[4*s]     = cx + span(scale / 2);
      p.v[4*s + 1] = cy + span(scale / 2);
      p.v[4*s + 2] = ($urandom_range(19) == 0) ? -w : w;
      p.v[4*s + 3] = $urandom_range(scale);
      if ($urandom_range(7) == 0) p.v[4*s + 1] = p.v[4*s];
      // boxes store max corner; the odd one comes out inverted
      if (p.cmd == CMD_BOX_BOX || (p.cmd == CMD_BOX_CIRCLE && s == 0) ||
          (p.cmd == CMD_CIRCLE_BOX && s == 1)) begin
        p.v[4*s + 2] = p.v[4*s] + (($urandom_range(19) == 0) ? -w : w);
        p.v[4*s + 3] = p.v[4*s + 1] + (($urandom_range(19) == 0) ? -w : int'($urandom_range(scale)));
      end
    end
    return p;
  endfunction

  initial begin
    pair_t directed[$];
    int max_i, min_i, u;
    max_i = 32'h7fff_ffff;
    min_i = 32'h8000_0000;
    u = 65536;
    directed = '{
      mk(CMD_BOX_BOX, 0, 0, 4*u, 2*u, 3*u, u, 6*u, 4*u),
      mk(CMD_BOX_BOX, 0, 0, 2*u, 4*u, u, 3*u, 4*u, 6*u),
      mk(CMD_BOX_BOX, 0, 0, 2*u, 2*u, 0, 0, 2*u, 2*u),
      mk(CMD_BOX_BOX, 0, 0, 2*u, 4*u, -u, 0, u, 4*u),
      mk(CMD_BOX_BOX, 0, 0, u, u, 3*u, 3*u, 5*u, 5*u),
      mk(CMD_BOX_BOX, 0, 0, u, u, u, 0, 2*u, u),
      mk(CMD_BOX_CIRCLE, 0, 0, 4*u, 4*u, 2*u, 2*u, u, 0),
      mk(CMD_BOX_CIRCLE, 0, 0, 4*u, 4*u, 5*u, 5*u, 2*u, 0),
      mk(CMD_BOX_CIRCLE, 0, 0, 4*u, 4*u, 9*u, 9*u, u, 0),
      mk(CMD_BOX_CIRCLE, 0, 0, 4*u, 4*u, 2*u, 2*u, -u, 0),
      mk(CMD_BOX_CIRCLE, 4*u, 4*u, 0, 0, 2*u, 5*u, 3*u, 0),
      mk(CMD_CIRCLE_CIRCLE, u, 2*u, 3*u, 0, u, 2*u, u, 0),
      mk(CMD_CIRCLE_CIRCLE, 0, 0, 2*u, 0, 3*u, 4*u, 4*u, 0),
      mk(CMD_CIRCLE_CIRCLE, 0, 0, u, 0, 9*u, 9*u, u, 0),
      mk(CMD_CIRCLE_BOX, 5*u, 2*u, 2*u, 0, 0, 0, 4*u, 4*u),
      mk(CMD_CIRCLE_BOX, 2*u, 2*u, u, 0, 0, 0, 4*u, 4*u),
      mk(CMD_BOX_BOX, min_i, min_i, max_i, max_i, min_i, min_i, max_i, max_i),
      mk(CMD_BOX_CIRCLE, min_i, min_i, max_i, max_i, max_i, min_i, max_i, max_i),
      mk(CMD_CIRCLE_CIRCLE, min_i, min_i, max_i, max_i, max_i, max_i, max_i, min_i),
      mk(CMD_CIRCLE_BOX, max_i, max_i, max_i, min_i, min_i, min_i, 0, 0),
      mk(CMD_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(CMD_BOX_BOX, -1, -1, -1, -1, -1, -1, -1, -1)
    };
    @(negedge rst);
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < 445; n++) begin
        // long receiver hold-off while the sender keeps offering items
        if (phase == 0 && n == 100) hold_cycles = 400;
        send(random_pair());
      end
      drain();
    end

    $display("covered %0d pairs (box-box %0d, box-circle %0d, circle-circle %0d, circle-box %0d)",
             contacts.matched, contacts.per_cmd[0], contacts.per_cmd[1],
             contacts.per_cmd[2], contacts.per_cmd[3]);
    $display("%0d contacts, four idling patterns, one long output hold-off, %0d mismatches",
             contacts.hits, contacts.errors);
    if (contacts.errors == 0 && contacts.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### box_circle_contact_unit.f
hdl/bccu_pkg.sv
hdl/bccu_sqrt.sv
hdl/bccu_div.sv
hdl/box_circle_contact_unit.sv
test/tb_top.sv
